>>> rtl/vmd_pkg.sv
// shared types and constants of the median-of-seven volume downsampler
package vmd_pkg;

    // voxel intensity
    typedef logic signed [15:0] vox_t;

    // width of size values and size compares
    localparam int unsigned SIZE_W = 11;
    localparam int unsigned HALF_W = 10;
    localparam int unsigned POSZ_W = 10;
    localparam int unsigned Z_LIMIT = 1024;

    // register index codes, taken from paddr[3:2]
    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;

    // per-item selection flags passed from the store control to the median unit
    typedef struct packed {
        logic im_clamp;
        logic ip_clamp;
        logic jm_clamp;
        logic jp_clamp;
        logic fwd_ctr;
        logic fwd_ip;
        logic fwd_jp;
        logic use_old;
        logic use_v;
        logic done;
    } sel_t;

endpackage

>>> rtl/volume_median7_downsample.sv
// top level: 3d median-of-seven downsampler by two with a two-plane bank store
// a voxel transfer that completes an output passes p1, then median stages a, b and c
// throughput: one voxel per cycle, set by one write and two reads per bank each cycle
// stalls only when the output register is full and not taken
// reset: sizes return to 256 and the position to the volume start, store is not cleared
// any size register write also returns the position to the volume start
module volume_median7_downsample #(
    parameter int unsigned MAX_X = 256,
    parameter int unsigned MAX_Y = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // voxel input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // voxel_value
    // median output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // median_value
    output logic        m_tlast    // volume_done
);

    // position widths: x and y split into a bank index and a parity bit
    localparam int unsigned XW = (MAX_X < 3) ? 2 : $clog2(MAX_X);
    localparam int unsigned YW = (MAX_Y < 3) ? 2 : $clog2(MAX_Y);
    localparam int unsigned IW = XW - 1;
    localparam int unsigned JW = YW - 1;
    localparam int unsigned AW = IW + JW;

    localparam int unsigned SW = vmd_pkg::SIZE_W;
    localparam int unsigned HW = vmd_pkg::HALF_W;

    // size registers
    logic [8:0]  size_x_reg, size_y_reg;
    logic [10:0] size_z_reg;
    logic        cfg_we;

    // effective sizes and output grid sizes
    logic [SW-1:0] sx, sy, sz;
    logic [HW-1:0] nxg, nyg, nzg;

    // input position
    logic [XW-1:0]               pos_x_reg, pos_x_next;
    logic [YW-1:0]               pos_y_reg, pos_y_next;
    logic [vmd_pkg::POSZ_W-1:0]  pos_z_reg, pos_z_next;

    logic          adv, acc;
    logic          x0, y0, slot;
    logic [IW-1:0] iw;
    logic [JW-1:0] jw;
    logic [HW-1:0] ii, jj, kk;
    logic          sz2, sy2, sx2, emit;
    logic          x_last, y_last, z_last;
    vmd_pkg::vox_t vox;
    vmd_pkg::sel_t sel_next, p1_sel_reg;
    logic          p1_vld_reg;
    vmd_pkg::vox_t p1_vox_reg;

    vmd_pkg::vox_t ee_a, ee_b, oe_a, oe_b, eo_a, eo_b;
    logic          med_valid, med_done;
    vmd_pkg::vox_t med_value;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[1:0] == 2'b00)
                    && (paddr[3:2] == vmd_pkg::REG_SIZE_X || paddr[3:2] == vmd_pkg::REG_SIZE_Y
                        || paddr[3:2] == vmd_pkg::REG_SIZE_Z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= 9'd256;
            size_y_reg <= 9'd256;
            size_z_reg <= 11'd256;
        end
        else if (cfg_we)
        begin
            case (paddr[3:2])
                vmd_pkg::REG_SIZE_X: size_x_reg <= pwdata[8:0];
                vmd_pkg::REG_SIZE_Y: size_y_reg <= pwdata[8:0];
                vmd_pkg::REG_SIZE_Z: size_z_reg <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            vmd_pkg::REG_SIZE_X: prdata = {23'd0, size_x_reg};
            vmd_pkg::REG_SIZE_Y: prdata = {23'd0, size_y_reg};
            vmd_pkg::REG_SIZE_Z: prdata = {21'd0, size_z_reg};
            default:             prdata = 32'd0;
        endcase
    end

    // zero acts as one, oversize acts as the maximum
    always_comb
    begin
        if (size_x_reg == 9'd0)
            sx = SW'(1);
        else if (SW'(size_x_reg) > SW'(MAX_X))
            sx = SW'(MAX_X);
        else
            sx = SW'(size_x_reg);
        if (size_y_reg == 9'd0)
            sy = SW'(1);
        else if (SW'(size_y_reg) > SW'(MAX_Y))
            sy = SW'(MAX_Y);
        else
            sy = SW'(size_y_reg);
        if (size_z_reg == 11'd0)
            sz = SW'(1);
        else if (size_z_reg > SW'(vmd_pkg::Z_LIMIT))
            sz = SW'(vmd_pkg::Z_LIMIT);
        else
            sz = size_z_reg;
    end

    // output grid size per axis, floored and at least one
    assign nxg = (sx[SW-1:1] == '0) ? HW'(1) : sx[SW-1:1];
    assign nyg = (sy[SW-1:1] == '0) ? HW'(1) : sy[SW-1:1];
    assign nzg = (sz[SW-1:1] == '0) ? HW'(1) : sz[SW-1:1];

    // ------------------------------------------------------------------
    // stream control: pipeline moves whenever the output register frees
    // ------------------------------------------------------------------
    assign adv      = !med_valid || m_tready;
    assign s_tready = adv;
    assign acc      = s_tvalid && s_tready;
    assign vox      = vmd_pkg::vox_t'(s_tdata);

    assign x0   = pos_x_reg[0];
    assign y0   = pos_y_reg[0];
    assign slot = pos_z_reg[0];
    assign iw   = pos_x_reg[XW-1:1];
    assign jw   = pos_y_reg[YW-1:1];
    assign ii   = HW'(iw);
    assign jj   = HW'(jw);
    assign kk   = HW'(pos_z_reg[vmd_pkg::POSZ_W-1:1]);

    assign sz2 = sz >= SW'(2);
    assign sy2 = sy >= SW'(2);
    assign sx2 = sx >= SW'(2);

    // an output is due when the last of its seven voxels arrives
    always_comb
    begin
        if (sz2)
            emit = slot && kk < nzg && !x0 && ii < nxg && !y0 && jj < nyg;
        else if (sy2)
            emit = y0 && jj < nyg && !x0 && ii < nxg;
        else if (sx2)
            emit = x0 && ii < nxg;
        else
            emit = 1'b1;
    end

    // neighbor clamping at the volume edges, and forwarding of the voxel now written
    always_comb
    begin
        sel_next.im_clamp = (iw == '0);
        sel_next.ip_clamp = SW'({iw, 1'b1}) >= sx;
        sel_next.jm_clamp = (jw == '0);
        sel_next.jp_clamp = SW'({jw, 1'b1}) >= sy;
        sel_next.fwd_ctr  = !sz2 && !sy2 && !sx2;
        sel_next.fwd_ip   = !sz2 && !sy2 && sx2;
        sel_next.fwd_jp   = !sz2 && sy2;
        sel_next.use_old  = sz2 && (kk != '0);
        sel_next.use_v    = sz2;
        sel_next.done     = (ii == nxg - HW'(1)) && (jj == nyg - HW'(1))
                            && (kk == nzg - HW'(1));
    end

    // raster position
    assign x_last = SW'(pos_x_reg) + SW'(1) >= sx;
    assign y_last = SW'(pos_y_reg) + SW'(1) >= sy;
    assign z_last = SW'(pos_z_reg) + SW'(1) >= sz;

    always_comb
    begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        pos_z_next = pos_z_reg;
        if (cfg_we)
        begin
            pos_x_next = '0;
            pos_y_next = '0;
            pos_z_next = '0;
        end
        else if (acc)
        begin
            pos_x_next = pos_x_reg + XW'(1);
            if (x_last)
            begin
                pos_x_next = '0;
                pos_y_next = pos_y_reg + YW'(1);
                if (y_last)
                begin
                    pos_y_next = '0;
                    pos_z_next = z_last ? '0 : pos_z_reg + vmd_pkg::POSZ_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            pos_z_reg  <= '0;
            p1_vld_reg <= 1'b0;
        end
        else
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            pos_z_reg <= pos_z_next;
            if (adv)
                p1_vld_reg <= acc && emit;
        end
    end

    // flags ride alongside the memory read data
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_sel_reg <= sel_next;
            p1_vox_reg <= vox;
        end
    end

    // ------------------------------------------------------------------
    // plane store split by x/y parity; only read banks are kept
    //   ee: even x even y, both slots (slot bit on top, odd plane is the old plane)
    //   oe: odd x even y, even planes only
    //   eo: even x odd y, even planes only
    // ------------------------------------------------------------------
    vmd_bank_ram #(.AW(AW + 1)) u_ee_ram (
        .clk     (clk),
        .en      (adv),
        .we      (acc && !x0 && !y0),
        .waddr   ({slot, jw, iw}),
        .wdata   (vox),
        .raddr_a ({1'b0, jw, iw}),
        .raddr_b ({1'b1, jw, iw}),
        .rdata_a (ee_a),
        .rdata_b (ee_b)
    );

    vmd_bank_ram #(.AW(AW)) u_oe_ram (
        .clk     (clk),
        .en      (adv),
        .we      (acc && x0 && !y0 && !slot),
        .waddr   ({jw, iw}),
        .wdata   (vox),
        .raddr_a ({jw, iw - IW'(1)}),
        .raddr_b ({jw, iw}),
        .rdata_a (oe_a),
        .rdata_b (oe_b)
    );

    vmd_bank_ram #(.AW(AW)) u_eo_ram (
        .clk     (clk),
        .en      (adv),
        .we      (acc && !x0 && y0 && !slot),
        .waddr   ({jw, iw}),
        .wdata   (vox),
        .raddr_a ({jw - JW'(1), iw}),
        .raddr_b ({jw, iw}),
        .rdata_a (eo_a),
        .rdata_b (eo_b)
    );

    // ------------------------------------------------------------------
    // median network, its last stage is the output register
    // ------------------------------------------------------------------
    vmd_median7 u_median (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .in_valid   (p1_vld_reg),
        .sel        (p1_sel_reg),
        .vox        (p1_vox_reg),
        .ee_a       (ee_a),
        .ee_b       (ee_b),
        .oe_a       (oe_a),
        .oe_b       (oe_b),
        .eo_a       (eo_a),
        .eo_b       (eo_b),
        .out_valid  (med_valid),
        .out_median (med_value),
        .out_done   (med_done)
    );

    assign m_tvalid = med_valid;
    assign m_tdata  = med_value;
    assign m_tlast  = med_done;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output stalled");

    a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (pos_x_reg == '0 && pos_y_reg == '0 && pos_z_reg == '0))
        else $error("position not restarted by size write");

    a_pos_in_volume: assert property (@(posedge clk) disable iff (!rst_n)
        (SW'(pos_x_reg) < sx) && (SW'(pos_y_reg) < sy) && (SW'(pos_z_reg) < sz))
        else $error("position outside volume");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (p1_vld_reg && !adv) |=> p1_vld_reg)
        else $error("pending item lost while stalled");

endmodule

>>> rtl/vmd_bank_ram.sv
// one plane bank: synchronous memory with one write and two registered reads
module vmd_bank_ram #(
    parameter int unsigned AW = 14
) (
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  vmd_pkg::vox_t     wdata,
    input  logic [AW-1:0]     raddr_a,
    input  logic [AW-1:0]     raddr_b,
    output vmd_pkg::vox_t     rdata_a,
    output vmd_pkg::vox_t     rdata_b
);

    vmd_pkg::vox_t mem [2**AW];

    // read before write on a shared address
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

>>> rtl/vmd_median7.sv
// selection of the seven voxels and a three-stage median-of-seven network
module vmd_median7 (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  vmd_pkg::sel_t    sel,
    input  vmd_pkg::vox_t    vox,
    input  vmd_pkg::vox_t    ee_a,
    input  vmd_pkg::vox_t    ee_b,
    input  vmd_pkg::vox_t    oe_a,
    input  vmd_pkg::vox_t    oe_b,
    input  vmd_pkg::vox_t    eo_a,
    input  vmd_pkg::vox_t    eo_b,
    output logic             out_valid,
    output vmd_pkg::vox_t    out_median,
    output logic             out_done
);

    typedef struct packed {
        vmd_pkg::vox_t lo;
        vmd_pkg::vox_t hi;
    } pair_t;

    function automatic pair_t cx(input vmd_pkg::vox_t a, input vmd_pkg::vox_t b);
        pair_t p;
        if (a > b)
        begin
            p.lo = b;
            p.hi = a;
        end
        else
        begin
            p.lo = a;
            p.hi = b;
        end
        return p;
    endfunction

    vmd_pkg::vox_t a_next [7];
    vmd_pkg::vox_t a_reg  [7];
    vmd_pkg::vox_t b_next [3];
    vmd_pkg::vox_t b_reg  [3];
    vmd_pkg::vox_t c_next;
    logic          a_vld_reg, b_vld_reg, c_vld_reg;
    logic          a_done_reg, b_done_reg, c_done_reg;
    vmd_pkg::vox_t c_reg;

    // stage a: pick the seven voxels, then the first three layers
    always_comb
    begin
        vmd_pkg::vox_t w [7];
        vmd_pkg::vox_t ctr;
        pair_t p, q;
        ctr  = sel.fwd_ctr ? vox : ee_a;
        w[0] = ctr;
        w[1] = sel.im_clamp ? ctr : oe_a;
        w[2] = sel.ip_clamp ? ctr : (sel.fwd_ip ? vox : oe_b);
        w[3] = sel.jm_clamp ? ctr : eo_a;
        w[4] = sel.jp_clamp ? ctr : (sel.fwd_jp ? vox : eo_b);
        w[5] = sel.use_old ? ee_b : ctr;
        w[6] = sel.use_v ? vox : ctr;
        p = cx(w[0], w[1]); w[0] = p.lo; w[1] = p.hi;
        q = cx(w[4], w[5]); w[4] = q.lo; w[5] = q.hi;
        p = cx(w[1], w[2]); w[1] = p.lo; w[2] = p.hi;
        q = cx(w[5], w[6]); w[5] = q.lo; w[6] = q.hi;
        p = cx(w[0], w[1]); w[0] = p.lo; w[1] = p.hi;
        q = cx(w[4], w[5]); w[4] = q.lo; w[5] = q.hi;
        a_next = w;
    end

    // stage b: layers four to six, only the middle three survive
    always_comb
    begin
        vmd_pkg::vox_t w [7];
        pair_t p;
        w = a_reg;
        p = cx(w[0], w[4]); w[0] = p.lo; w[4] = p.hi;
        p = cx(w[2], w[6]); w[2] = p.lo; w[6] = p.hi;
        p = cx(w[1], w[3]); w[1] = p.lo; w[3] = p.hi;
        p = cx(w[3], w[5]); w[3] = p.lo; w[5] = p.hi;
        p = cx(w[1], w[3]); w[1] = p.lo; w[3] = p.hi;
        b_next[0] = w[2];
        b_next[1] = w[3];
        b_next[2] = w[4];
    end

    // stage c: last three layers
    always_comb
    begin
        vmd_pkg::vox_t w2, w3, w4;
        pair_t p;
        w2 = b_reg[0];
        w3 = b_reg[1];
        w4 = b_reg[2];
        p = cx(w2, w3); w2 = p.lo; w3 = p.hi;
        p = cx(w3, w4); w3 = p.lo; w4 = p.hi;
        p = cx(w2, w3); w2 = p.lo; w3 = p.hi;
        c_next = w3;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= in_valid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg      <= a_next;
            a_done_reg <= sel.done;
            b_reg      <= b_next;
            b_done_reg <= a_done_reg;
            c_reg      <= c_next;
            c_done_reg <= b_done_reg;
        end
    end

    assign out_valid  = c_vld_reg;
    assign out_median = c_reg;
    assign out_done   = c_done_reg;

endmodule
